>>> sv/rrsw_pkg.sv
// ----------------------------------------------------------------------------
// Scheduler package
// Shared constants, command and status codes, and controller/datapath types
// for the round-robin sleep/wake scheduler.
// ----------------------------------------------------------------------------
package rrsw_pkg;

   localparam int SLOT_COUNT_DEF = 16;
   localparam int KEY_BITS_DEF   = 16;
   localparam int INPUT_KEY_BITS = 16;

   // request command codes
   localparam logic [1:0] CMD_YIELD = 2'd0;
   localparam logic [1:0] CMD_SLEEP = 2'd1;
   localparam logic [1:0] CMD_WAKE  = 2'd2;
   localparam logic [1:0] CMD_ADMIT = 2'd3;

   // response status codes
   localparam logic [1:0] STAT_OK         = 2'd0;
   localparam logic [1:0] STAT_FULL       = 2'd1;
   localparam logic [1:0] STAT_IDLE_SLEEP = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_POP_YIELD,
      ST_POP_SLEEP,
      ST_WAKE_READ,
      ST_WAKE_ACT,
      ST_ADMIT_SCAN,
      ST_FINISH
   } ctrl_state_type;

   // controller to datapath
   typedef struct packed {
      logic latch_req;
      logic read_head;
      logic pop;
      logic requeue;
      logic run_idle;
      logic append_waiter;
      logic idle_sleep;
      logic wake_start;
      logic wait_read;
      logic wait_act;
      logic wake_finish;
      logic admit_start;
      logic admit_next;
      logic admit_claim;
      logic admit_fail;
      logic load_out;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [1:0] command;
      logic       count_zero;
      logic       cur_idle;
      logic       wake_more;
      logic       scan_end;
      logic       slot_used;
      logic       out_free;
   } dp_stat_type;

endpackage

>>> sv/rrsw_control.sv
// ----------------------------------------------------------------------------
// Scheduler controller
// Sequences one command at a time through decode, queue pops, the wake scan
// and the admit scan, then hands the result to the output register.
// ----------------------------------------------------------------------------
module rrsw_control
   import rrsw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   ctrl_state_type state_ff, state_in;

   // advance state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            unique case (stat.command)
               CMD_YIELD: state_in = stat.count_zero ? ST_FINISH : ST_POP_YIELD;
               CMD_SLEEP: begin
                  if (stat.cur_idle || stat.count_zero) state_in = ST_FINISH;
                  else state_in = ST_POP_SLEEP;
               end
               CMD_WAKE:  state_in = ST_WAKE_READ;
               CMD_ADMIT: state_in = ST_ADMIT_SCAN;
               default:   state_in = ST_FINISH;
            endcase
         end
         ST_POP_YIELD,
         ST_POP_SLEEP: state_in = ST_FINISH;
         ST_WAKE_READ: state_in = stat.wake_more ? ST_WAKE_ACT : ST_FINISH;
         ST_WAKE_ACT:  state_in = ST_WAKE_READ;
         ST_ADMIT_SCAN: begin
            if (stat.scan_end || !stat.slot_used) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (stat.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // drive datapath commands
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.latch_req = req_valid;
         end
         ST_DECODE: begin
            unique case (stat.command)
               CMD_YIELD: cmd.read_head = !stat.count_zero;
               CMD_SLEEP: begin
                  if (stat.cur_idle) begin
                     cmd.idle_sleep = 1'b1;
                  end else begin
                     cmd.append_waiter = 1'b1;
                     cmd.read_head     = !stat.count_zero;
                     cmd.run_idle      = stat.count_zero;
                  end
               end
               CMD_WAKE:  cmd.wake_start  = 1'b1;
               CMD_ADMIT: cmd.admit_start = 1'b1;
               default:   cmd.wake_start  = 1'b0;
            endcase
         end
         ST_POP_YIELD: begin
            cmd.pop     = 1'b1;
            cmd.requeue = 1'b1;
         end
         ST_POP_SLEEP: cmd.pop = 1'b1;
         ST_WAKE_READ: begin
            cmd.wait_read   = stat.wake_more;
            cmd.wake_finish = !stat.wake_more;
         end
         ST_WAKE_ACT: cmd.wait_act = 1'b1;
         ST_ADMIT_SCAN: begin
            if (stat.scan_end) cmd.admit_fail = 1'b1;
            else if (!stat.slot_used) cmd.admit_claim = 1'b1;
            else cmd.admit_next = 1'b1;
         end
         ST_FINISH: cmd.load_out = stat.out_free;
         default: cmd = '0;
      endcase
   end

endmodule

>>> sv/rrsw_datapath.sv
// ----------------------------------------------------------------------------
// Scheduler datapath
// Holds the running slot, slot-use flags, the ready FIFO memory, the ordered
// wait-list memory, scan counters and the response register.
// ----------------------------------------------------------------------------
module rrsw_datapath
   import rrsw_pkg::*;
#(
   parameter int SLOT_COUNT = SLOT_COUNT_DEF,
   parameter int KEY_BITS   = KEY_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [1:0]                req_command,
   input  logic [INPUT_KEY_BITS-1:0] req_wait_key,
   input  logic                      rsp_ready,
   output logic                      rsp_valid,
   output logic [3:0]                rsp_running_slot,
   output logic                      rsp_switched,
   output logic [3:0]                rsp_new_slot,
   output logic [4:0]                rsp_woken_count,
   output logic [1:0]                rsp_status,
   input  dp_cmd_type                cmd,
   output dp_stat_type               stat
);

   localparam int SW = $clog2(SLOT_COUNT);
   localparam int CW = SW + 1;
   localparam int KW = (KEY_BITS < INPUT_KEY_BITS) ? KEY_BITS : INPUT_KEY_BITS;
   localparam logic [CW-1:0] SLOTS = CW'(SLOT_COUNT);

   // memories
   logic [SW-1:0] fifo_mem  [SLOT_COUNT];
   logic [SW-1:0] wslot_mem [SLOT_COUNT];
   logic [KW-1:0] wkey_mem  [SLOT_COUNT];

   logic [SW-1:0]         cur_ff, before_ff, head_ff, fifo_rd_ff, wslot_rd_ff;
   logic [KW-1:0]         wkey_rd_ff, key_ff;
   logic [CW-1:0]         count_ff, wcount_ff, i_ff, j_ff, woken_ff;
   logic [1:0]            command_ff, status_ff;
   logic [SW-1:0]         new_slot_ff;
   logic [SLOT_COUNT-1:0] used_ff;
   logic                  rsp_valid_ff;
   logic [3:0]            out_slot_ff, out_new_ff;
   logic                  out_sw_ff;
   logic [4:0]            out_woken_ff;
   logic [1:0]            out_status_ff;

   logic [CW-1:0] tail_sum;
   logic [SW-1:0] tail, head_next;
   logic          fifo_we;
   logic [SW-1:0] fifo_wdata;
   logic          key_match, can_push;

   // compute tail slot and head wrap
   always_comb begin
      tail_sum  = CW'(head_ff) + count_ff;
      tail      = (tail_sum >= SLOTS) ? SW'(tail_sum - SLOTS) : SW'(tail_sum);
      head_next = (CW'(head_ff) == SLOTS - 1'b1) ? '0 : head_ff + 1'b1;
      key_match = (wkey_rd_ff == key_ff);
      can_push  = (count_ff < SLOTS);
   end

   // select the FIFO write source
   always_comb begin
      fifo_we    = 1'b0;
      fifo_wdata = cur_ff;
      if (cmd.pop && cmd.requeue && cur_ff != '0) begin
         fifo_we = 1'b1;
      end else if (cmd.wait_act && key_match && can_push) begin
         fifo_we    = 1'b1;
         fifo_wdata = wslot_rd_ff;
      end else if (cmd.admit_claim && can_push) begin
         fifo_we    = 1'b1;
         fifo_wdata = i_ff[SW-1:0];
      end
   end

   // ready FIFO memory
   always_ff @(posedge clock) begin
      if (fifo_we) fifo_mem[tail] <= fifo_wdata;
      if (cmd.read_head) fifo_rd_ff <= fifo_mem[head_ff];
   end

   // wait-list memory: append or compact on write, scan on read
   always_ff @(posedge clock) begin
      if (cmd.append_waiter && wcount_ff < SLOTS) begin
         wslot_mem[wcount_ff[SW-1:0]] <= cur_ff;
         wkey_mem[wcount_ff[SW-1:0]]  <= key_ff;
      end else if (cmd.wait_act && !key_match) begin
         wslot_mem[j_ff[SW-1:0]] <= wslot_rd_ff;
         wkey_mem[j_ff[SW-1:0]]  <= wkey_rd_ff;
      end
      if (cmd.wait_read) begin
         wslot_rd_ff <= wslot_mem[i_ff[SW-1:0]];
         wkey_rd_ff  <= wkey_mem[i_ff[SW-1:0]];
      end
   end

   // request latch and per-item results
   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         command_ff  <= req_command;
         key_ff      <= req_wait_key[KW-1:0];
         before_ff   <= cur_ff;
         new_slot_ff <= '0;
         woken_ff    <= '0;
         status_ff   <= STAT_OK;
      end
      if (cmd.idle_sleep) status_ff <= STAT_IDLE_SLEEP;
      if (cmd.admit_fail) status_ff <= STAT_FULL;
      if (cmd.admit_claim) new_slot_ff <= i_ff[SW-1:0];
      if (cmd.wait_act && key_match) woken_ff <= woken_ff + 1'b1;
   end

   // scheduler control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff    <= '0;
         head_ff   <= '0;
         count_ff  <= '0;
         wcount_ff <= '0;
         used_ff   <= SLOT_COUNT'(1);
         i_ff      <= '0;
         j_ff      <= '0;
      end else begin
         // pop the ready head, requeue the running task on yield unless it is idle
         if (cmd.pop) begin
            cur_ff  <= fifo_rd_ff;
            head_ff <= head_next;
            if (!(cmd.requeue && cur_ff != '0)) count_ff <= count_ff - 1'b1;
         end
         if (cmd.run_idle) cur_ff <= '0;
         if (cmd.append_waiter && wcount_ff < SLOTS) wcount_ff <= wcount_ff + 1'b1;
         if (cmd.wake_start) begin
            i_ff <= '0;
            j_ff <= '0;
         end
         if (cmd.wait_act) begin
            i_ff <= i_ff + 1'b1;
            if (key_match) begin
               if (can_push) count_ff <= count_ff + 1'b1;
            end else begin
               j_ff <= j_ff + 1'b1;
            end
         end
         if (cmd.wake_finish) wcount_ff <= j_ff;
         if (cmd.admit_start) i_ff <= CW'(1);
         if (cmd.admit_next) i_ff <= i_ff + 1'b1;
         if (cmd.admit_claim) begin
            used_ff[i_ff[SW-1:0]] <= 1'b1;
            if (can_push) count_ff <= count_ff + 1'b1;
         end
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.load_out) begin
         out_slot_ff   <= 4'(cur_ff);
         out_sw_ff     <= (cur_ff != before_ff);
         out_new_ff    <= 4'(new_slot_ff);
         out_woken_ff  <= 5'(woken_ff);
         out_status_ff <= status_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_running_slot = out_slot_ff;
   assign rsp_switched     = out_sw_ff;
   assign rsp_new_slot     = out_new_ff;
   assign rsp_woken_count  = out_woken_ff;
   assign rsp_status       = out_status_ff;

   // status to controller
   always_comb begin
      stat.command    = command_ff;
      stat.count_zero = (count_ff == '0);
      stat.cur_idle   = (cur_ff == '0);
      stat.wake_more  = (i_ff < wcount_ff);
      stat.scan_end   = (i_ff == SLOTS);
      stat.slot_used  = used_ff[i_ff[SW-1:0]];
      stat.out_free   = !rsp_valid_ff || rsp_ready;
   end

endmodule

>>> sv/round_robin_sleep_wake_scheduler_top.sv
// ----------------------------------------------------------------------------
// Round-robin sleep/wake scheduler top level
// Task scheduler over a fixed slot table with a ready FIFO and wait list.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel takes one command beat (yield, sleep, wake, admit) with a
//   wait key. The rsp channel returns one beat per command: the running slot,
//   a switch flag, the admitted slot, the woken count and a status code.
//   Commands are processed one at a time. Yield, and a sleep that does not
//   come from the idle slot, pop the ready head when it is not empty; in a
//   wake each wait-list entry needs a registered memory read and then a move
//   or compact step; admit scans one slot-use flag a cycle, plus one end
//   check on a full table. The controller passes through the idle state
//   before the next accept.
//   After reset slot 0 (the idle task) is running, all other slots are
//   unused and both queues are empty; no clearing pass is needed.
//   The result sits in an output register; the next command is accepted
//   while it waits, and its own result then holds until rsp_ready frees the
//   register.
// ----------------------------------------------------------------------------
module round_robin_sleep_wake_scheduler_top
   import rrsw_pkg::*;
#(
   parameter int SLOT_COUNT = SLOT_COUNT_DEF,
   parameter int KEY_BITS   = KEY_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_command,
   input  logic [INPUT_KEY_BITS-1:0] req_wait_key,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [3:0]                rsp_running_slot,
   output logic                      rsp_switched,
   output logic [3:0]                rsp_new_slot,
   output logic [4:0]                rsp_woken_count,
   output logic [1:0]                rsp_status
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   rrsw_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   rrsw_datapath #(
      .SLOT_COUNT (SLOT_COUNT),
      .KEY_BITS   (KEY_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_command      (req_command),
      .req_wait_key     (req_wait_key),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_running_slot (rsp_running_slot),
      .rsp_switched     (rsp_switched),
      .rsp_new_slot     (rsp_new_slot),
      .rsp_woken_count  (rsp_woken_count),
      .rsp_status       (rsp_status),
      .cmd              (cmd),
      .stat             (stat)
   );

endmodule

>>> sv/rrsw_checker.sv
// ----------------------------------------------------------------------------
// Scheduler port checker
// Watches the response channel for results that contradict each other.
// ----------------------------------------------------------------------------
module rrsw_checker
   import rrsw_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [3:0] rsp_running_slot,
   input logic       rsp_switched,
   input logic [3:0] rsp_new_slot,
   input logic [4:0] rsp_woken_count,
   input logic [1:0] rsp_status
);

   // hold a stalled response beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_running_slot)
                                  && $stable(rsp_status))
      else $error("response beat changed while stalled");

   // a full table gives no slot
   a_full_no_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STAT_FULL |-> rsp_new_slot == 4'd0 && !rsp_switched)
      else $error("failed admit reported a slot");

   // idle sleep leaves idle running
   a_idle_sleep: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STAT_IDLE_SLEEP |->
         rsp_running_slot == 4'd0 && !rsp_switched && rsp_woken_count == 5'd0)
      else $error("idle sleep changed the running task");

   // a wake never switches tasks
   a_wake_no_switch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_woken_count != 5'd0 |-> !rsp_switched && rsp_new_slot == 4'd0)
      else $error("wake switched tasks");

endmodule

bind round_robin_sleep_wake_scheduler_top rrsw_checker u_rrsw_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_running_slot (rsp_running_slot),
   .rsp_switched     (rsp_switched),
   .rsp_new_slot     (rsp_new_slot),
   .rsp_woken_count  (rsp_woken_count),
   .rsp_status       (rsp_status)
);

>>> verif/tb_round_robin_sleep_wake_scheduler_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scheduler checker
// Watches the command and response channels, keeps its own copy of the slot
// table, ready FIFO and wait list, and compares every response beat against
// the predicted result. Mismatches are counted and handed to the top.
// ----------------------------------------------------------------------------
module tb_round_robin_sleep_wake_scheduler_checker
   import rrsw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [15:0] req_wait_key,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [3:0]  rsp_running_slot,
   input  logic        rsp_switched,
   input  logic [3:0]  rsp_new_slot,
   input  logic [4:0]  rsp_woken_count,
   input  logic [1:0]  rsp_status,
   output int          error_count,
   output int          pending_count
);

   localparam int NSLOT = SLOT_COUNT_DEF;

   typedef enum logic [1:0] {
      SL_UNUSED,
      SL_READY,
      SL_RUNNING,
      SL_SLEEPING
   } slot_state_type;

   typedef struct packed {
      logic [3:0] running_slot;
      logic       switched;
      logic [3:0] new_slot;
      logic [4:0] woken_count;
      logic [1:0] status;
   } sched_result_type;

   slot_state_type   slot_state [NSLOT];
   logic [3:0]       ready_q [$];
   logic [3:0]       sleeper_slot [$];
   logic [15:0]      sleeper_key [$];
   logic [3:0]       cur_slot;
   sched_result_type expected_results [$];

   assign pending_count = expected_results.size();

   // Run the ready head, or idle when nothing is ready
   function automatic void dispatch_next();
      logic [3:0] nxt;
      nxt = 4'd0;
      if (ready_q.size() > 0) nxt = ready_q.pop_front();
      slot_state[nxt] = SL_RUNNING;
      cur_slot = nxt;
   endfunction

   function automatic sched_result_type schedule_command(logic [1:0] cmd, logic [15:0] key);
      sched_result_type r;
      logic [3:0]       prev;
      logic [3:0]       ks [$];
      logic [15:0]      kk [$];
      bit               found;
      r = '0;
      prev = cur_slot;
      found = 0;
      case (cmd)
         CMD_YIELD: begin
            if (ready_q.size() > 0) begin
               slot_state[cur_slot] = SL_READY;
               if (cur_slot != 0) ready_q.push_back(cur_slot);
               dispatch_next();
            end
         end
         CMD_SLEEP: begin
            if (cur_slot == 0) begin
               r.status = STAT_IDLE_SLEEP;
            end else begin
               slot_state[cur_slot] = SL_SLEEPING;
               sleeper_slot.push_back(cur_slot);
               sleeper_key.push_back(key);
               dispatch_next();
            end
         end
         CMD_WAKE: begin
            // move matching waiters in order, compact the rest
            foreach (sleeper_slot[i]) begin
               if (sleeper_key[i] == key) begin
                  slot_state[sleeper_slot[i]] = SL_READY;
                  ready_q.push_back(sleeper_slot[i]);
                  r.woken_count++;
               end else begin
                  ks.push_back(sleeper_slot[i]);
                  kk.push_back(sleeper_key[i]);
               end
            end
            sleeper_slot = ks;
            sleeper_key = kk;
         end
         default: begin
            for (int i = 1; i < NSLOT && !found; i++) begin
               if (slot_state[i] == SL_UNUSED) begin
                  slot_state[i] = SL_READY;
                  ready_q.push_back(4'(i));
                  r.new_slot = 4'(i);
                  found = 1;
               end
            end
            if (!found) r.status = STAT_FULL;
         end
      endcase
      r.running_slot = cur_slot;
      r.switched = (cur_slot != prev);
      return r;
   endfunction

   // Predict on command beats, compare on response beats
   always @(posedge clock) begin
      sched_result_type got, exp_r;
      if (reset) begin
         foreach (slot_state[i]) slot_state[i] = SL_UNUSED;
         slot_state[0] = SL_RUNNING;
         cur_slot = 0;
         ready_q.delete();
         sleeper_slot.delete();
         sleeper_key.delete();
         expected_results.delete();
         error_count <= 0;
      end else begin
         if (req_valid && req_ready)
            expected_results.push_back(schedule_command(req_command, req_wait_key));
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_running_slot, rsp_switched, rsp_new_slot, rsp_woken_count,
                    rsp_status};
            if (expected_results.size() == 0) begin
               $display("%0t: response beat with nothing expected, actual %h", $time, got);
               error_count <= error_count + 1;
            end else begin
               exp_r = expected_results.pop_front();
               if (got !== exp_r) begin
                  $display("%0t: mismatch expected slot=%0d sw=%0d new=%0d woken=%0d st=%0d",
                           $time, exp_r.running_slot, exp_r.switched, exp_r.new_slot,
                           exp_r.woken_count, exp_r.status);
                  $display("%0t:          actual   slot=%0d sw=%0d new=%0d woken=%0d st=%0d",
                           $time, got.running_slot, got.switched, got.new_slot,
                           got.woken_count, got.status);
                  error_count <= error_count + 1;
               end
            end
         end
      end
   end

endmodule

>>> verif/tb_round_robin_sleep_wake_scheduler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scheduler testbench top
// Drives directed and random command beats with random idling on both
// channels, and reports the checker's verdict at the end of the run.
// ----------------------------------------------------------------------------
module tb_round_robin_sleep_wake_scheduler_top;
   import rrsw_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [1:0]  req_command = CMD_YIELD;
   logic [15:0] req_wait_key = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [3:0]  rsp_running_slot;
   logic        rsp_switched;
   logic [3:0]  rsp_new_slot;
   logic [4:0]  rsp_woken_count;
   logic [1:0]  rsp_status;
   int          error_count;
   int          pending_count;
   int          idle_cycles = 0;
   int          rsp_hold = 0;
   bit          calm_phase = 0;
   logic [15:0] key_pool [4] = '{16'h0000, 16'hFFFF, 16'h5A5A, 16'h0001};

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   round_robin_sleep_wake_scheduler_top u_dut (.*);

   tb_round_robin_sleep_wake_scheduler_checker u_checker (.*);

   // Send one command beat, with an optional random gap before it
   task automatic send_command(logic [1:0] cmd, logic [15:0] key);
      if (!calm_phase && $urandom_range(0, 3) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid <= 1;
      req_command <= cmd;
      req_wait_key <= key;
      do @(posedge clock); while (!req_ready);
   endtask

   // Stall the response side in bursts of random length
   always @(posedge clock) begin
      if (reset || calm_phase) begin
         rsp_ready <= 1;
         rsp_hold  <= 0;
      end else if (rsp_hold > 0) begin
         rsp_hold <= rsp_hold - 1;
         if (rsp_hold == 1) rsp_ready <= 1;
      end else if ($urandom_range(0, 4) == 0) begin
         rsp_ready <= 0;
         rsp_hold  <= $urandom_range(1, 10);
      end
   end

   // Watchdog: count cycles with no beat on either channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      logic [1:0]  cmd;
      logic [15:0] key;
      int          roll;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: idle yield/sleep, admits to full, sleeps, wakes
      send_command(CMD_YIELD, 16'h0000);
      send_command(CMD_SLEEP, 16'h1234);
      send_command(CMD_WAKE, 16'hBEEF);
      repeat (16) send_command(CMD_ADMIT, 16'h0000);
      send_command(CMD_YIELD, 16'h0000);
      send_command(CMD_SLEEP, 16'hFFFF);
      send_command(CMD_SLEEP, 16'h0000);
      send_command(CMD_SLEEP, 16'hFFFF);
      send_command(CMD_WAKE, 16'hFFFF);
      send_command(CMD_WAKE, 16'h0000);
      send_command(CMD_YIELD, 16'hAAAA);
      req_valid <= 0;
      @(posedge clock);

      // Hold the sender until the checker has nothing outstanding
      while (pending_count != 0) @(posedge clock);

      // Random: mostly pooled keys so wakes find sleepers
      for (int n = 0; n < 700; n++) begin
         if (n == 600) calm_phase = 1;
         roll = $urandom_range(0, 9);
         cmd = roll < 3 ? CMD_YIELD : roll < 6 ? CMD_SLEEP : roll < 8 ? CMD_WAKE : CMD_ADMIT;
         key = ($urandom_range(0, 7) == 0) ? 16'($urandom) : key_pool[$urandom_range(0, 3)];
         send_command(cmd, key);
      end
      req_valid <= 0;
      @(posedge clock);

      while (pending_count != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (error_count == 0 && pending_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

>>> filelist.f
sv/rrsw_pkg.sv
sv/rrsw_control.sv
sv/rrsw_datapath.sv
sv/round_robin_sleep_wake_scheduler_top.sv
sv/rrsw_checker.sv
verif/tb_round_robin_sleep_wake_scheduler_checker.sv
verif/tb_round_robin_sleep_wake_scheduler_top.sv
